>>> hw/rtl/fbp_pkg.sv
// fbp_pkg: shared sizes, operation and status codes, mark bits and the command
// bundle for the flash block provisioner
// no dependencies
package fbp_pkg;

  localparam int LUNS           = 4;
  localparam int BLOCKS_PER_LUN = 1024;
  localparam int PLANES         = 2;
  localparam int TOTAL_BLOCKS   = LUNS * BLOCKS_PER_LUN;

  localparam int OP_W     = 3;
  localparam int LUN_W    = 2;
  localparam int BLK_W    = 10;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 11;
  localparam int MARK_W   = 3;
  localparam int ADDR_W   = $clog2(TOTAL_BLOCKS);

  // block mark bits
  localparam logic [MARK_W-1:0] MARK_USED = 3'b001;
  localparam logic [MARK_W-1:0] MARK_OPEN = 3'b010;
  localparam logic [MARK_W-1:0] MARK_BAD  = 3'b100;
  localparam logic [MARK_W-1:0] MARK_NONE = 3'b000;

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(BLOCKS_PER_LUN);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 3'd0,
    OP_GET   = 3'd1,
    OP_ERASE = 3'd2,
    OP_PUT   = 3'd3,
    OP_CLOSE = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_NO_FREE    = 3'd1,
    ST_NOT_USED   = 3'd2,
    ST_STILL_OPEN = 3'd3,
    ST_ERASE_FAIL = 3'd4,
    ST_NO_PENDING = 3'd5
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the item and start the memory reads
    logic commit;   // apply the update and load the result register
  } fbp_cmd_t;

  // flat address of a block in the shared memories
  function automatic logic [ADDR_W-1:0] blk_addr(input logic [LUN_W-1:0] lun,
                                                 input logic [BLK_W-1:0] blk);
    return ADDR_W'(lun) * ADDR_W'(BLOCKS_PER_LUN) + ADDR_W'(blk);
  endfunction

  // ring position after p
  function automatic logic [BLK_W-1:0] next_pos(input logic [BLK_W-1:0] p);
    logic [BLK_W:0] inc;
    inc = {1'b0, p} + 1'b1;
    return (inc >= (BLK_W + 1)'(BLOCKS_PER_LUN)) ? '0 : inc[BLK_W-1:0];
  endfunction

endpackage

>>> hw/rtl/fbp_req_if.sv
// fbp_req_if: request channel, valid/ready with one operation item
// depends on fbp_pkg
interface fbp_req_if import fbp_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [LUN_W-1:0]     lun;
  logic [BLK_W-1:0]     block;
  logic [PLANES-1:0]    bad_planes;
  logic                 stored_used;
  logic                 stored_open;
  logic                 erase_ok;

  modport source (output valid, operation, lun, block, bad_planes, stored_used,
                  stored_open, erase_ok, input ready);
  modport sink (input valid, operation, lun, block, bad_planes, stored_used,
                stored_open, erase_ok, output ready);
endinterface

>>> hw/rtl/fbp_rsp_if.sv
// fbp_rsp_if: response channel, valid/ready with one result item
// depends on fbp_pkg
interface fbp_rsp_if import fbp_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [BLK_W-1:0]     block_out;
  logic [COUNT_W-1:0]   free_count;
  logic [COUNT_W-1:0]   used_count;

  modport source (output valid, status, block_out, free_count, used_count,
                  input ready);
  modport sink (input valid, status, block_out, free_count, used_count,
                output ready);
endinterface

>>> hw/rtl/fbp_ctrl.sv
// fbp_ctrl: sequencer, one item at a time, capture then commit
// depends on fbp_pkg
module fbp_ctrl import fbp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output fbp_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.capture = ready_q && in_valid_i;
    cmd_o.commit  = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
    state_d       = state_q;
    ready_d       = ready_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.capture) begin
          state_d = S_EXEC;
          ready_d = 1'b0;
        end
      end
      S_EXEC: begin
        if (cmd_o.commit) begin
          state_d     = S_IDLE;
          ready_d     = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
        ready_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ready_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = ready_q;
  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/fbp_datapath.sv
// fbp_datapath: free rings, block marks, per-lun pointers and counts,
// pending get and the result register
// depends on fbp_pkg
module fbp_datapath import fbp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fbp_cmd_t             cmd_i,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [LUN_W-1:0]     lun_i,
  input  logic [BLK_W-1:0]     block_i,
  input  logic [PLANES-1:0]    bad_planes_i,
  input  logic                 stored_used_i,
  input  logic                 stored_open_i,
  input  logic                 erase_ok_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [BLK_W-1:0]     block_out_o,
  output logic [COUNT_W-1:0]   free_count_o,
  output logic [COUNT_W-1:0]   used_count_o
);

  // memories
  logic [BLK_W-1:0]   ring_mem  [TOTAL_BLOCKS];
  logic [MARK_W-1:0]  marks_mem [TOTAL_BLOCKS];

  // per-lun state
  logic [BLK_W-1:0]   head_q [LUNS];
  logic [BLK_W-1:0]   tail_q [LUNS];
  logic [COUNT_W-1:0] free_q [LUNS];
  logic [COUNT_W-1:0] used_q [LUNS];

  logic               pend_valid_q, pend_valid_d;
  logic [LUN_W-1:0]   pend_lun_q, pend_lun_d;
  logic [BLK_W-1:0]   pend_blk_q, pend_blk_d;

  // captured item and read data
  op_e                op_q;
  logic [LUN_W-1:0]   lun_q;
  logic [BLK_W-1:0]   blk_q;
  logic               bad_q;
  logic               s_used_q;
  logic               s_open_q;
  logic               e_ok_q;
  logic [BLK_W-1:0]   ring_rd_q;
  logic [MARK_W-1:0]  marks_rd_q;

  logic [ADDR_W-1:0]  marks_raddr;
  logic [ADDR_W-1:0]  ring_raddr;

  // update
  logic [LUN_W-1:0]   lun_eff;
  status_e            status_d;
  logic [BLK_W-1:0]   bout_d;
  logic [BLK_W-1:0]   head_d, tail_d;
  logic [COUNT_W-1:0] free_d, used_d;
  logic               ring_we;
  logic [ADDR_W-1:0]  ring_waddr;
  logic               marks_we;
  logic [ADDR_W-1:0]  marks_waddr;
  logic [MARK_W-1:0]  marks_wdata;

  logic [STATUS_W-1:0] status_q;
  logic [BLK_W-1:0]    bout_q;
  logic [COUNT_W-1:0]  free_cnt_q, used_cnt_q;

  // erase report reads the pending block's marks, the rest read the named block
  assign marks_raddr = (op_e'(operation_i) == OP_ERASE) ? blk_addr(pend_lun_q, pend_blk_q)
                                                        : blk_addr(lun_i, block_i);
  assign ring_raddr  = blk_addr(lun_i, head_q[lun_i]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= op_e'(operation_i);
      lun_q      <= lun_i;
      blk_q      <= block_i;
      bad_q      <= |bad_planes_i;
      s_used_q   <= stored_used_i;
      s_open_q   <= stored_open_i;
      e_ok_q     <= erase_ok_i;
      ring_rd_q  <= ring_mem[ring_raddr];
      marks_rd_q <= marks_mem[marks_raddr];
    end
  end

  assign lun_eff = (op_q == OP_ERASE && pend_valid_q) ? pend_lun_q : lun_q;

  always_comb begin
    status_d     = ST_OK;
    bout_d       = blk_q;
    head_d       = head_q[lun_eff];
    tail_d       = tail_q[lun_eff];
    free_d       = free_q[lun_eff];
    used_d       = used_q[lun_eff];
    pend_valid_d = pend_valid_q;
    pend_lun_d   = pend_lun_q;
    pend_blk_d   = pend_blk_q;
    ring_we      = 1'b0;
    ring_waddr   = blk_addr(lun_q, tail_q[lun_eff]);
    marks_we     = 1'b0;
    marks_waddr  = blk_addr(lun_q, blk_q);
    marks_wdata  = MARK_NONE;
    unique case (op_q)
      OP_LOAD: begin
        marks_we = 1'b1;
        if (bad_q) begin
          marks_wdata = MARK_BAD;
        end else if (s_used_q) begin
          marks_wdata = s_open_q ? (MARK_USED | MARK_OPEN) : MARK_USED;
          if (used_d < COUNT_MAX) used_d = used_d + 1'b1;
        end else begin
          marks_wdata = MARK_NONE;
          if (free_d < COUNT_MAX) begin
            ring_we = 1'b1;
            tail_d  = next_pos(tail_d);
            free_d  = free_d + 1'b1;
          end
        end
      end
      OP_GET: begin
        if (free_d == '0) begin
          status_d = ST_NO_FREE;
          bout_d   = '0;
        end else begin
          head_d       = next_pos(head_d);
          free_d       = free_d - 1'b1;
          if (used_d < COUNT_MAX) used_d = used_d + 1'b1;
          marks_we     = 1'b1;
          marks_waddr  = blk_addr(lun_q, ring_rd_q);
          marks_wdata  = MARK_USED;
          pend_valid_d = 1'b1;
          pend_lun_d   = lun_q;
          pend_blk_d   = ring_rd_q;
          bout_d       = ring_rd_q;
        end
      end
      OP_ERASE: begin
        if (!pend_valid_q) begin
          status_d = ST_NO_PENDING;
          bout_d   = '0;
        end else begin
          bout_d      = pend_blk_q;
          marks_we    = 1'b1;
          marks_waddr = blk_addr(pend_lun_q, pend_blk_q);
          if (e_ok_q) begin
            marks_wdata = MARK_USED | MARK_OPEN;
          end else begin
            if (((marks_rd_q & MARK_USED) != MARK_NONE) && (used_d != '0)) begin
              used_d = used_d - 1'b1;
            end
            marks_wdata = MARK_BAD;
            status_d    = ST_ERASE_FAIL;
          end
          pend_valid_d = 1'b0;
        end
      end
      OP_PUT: begin
        if ((marks_rd_q & MARK_USED) == MARK_NONE) begin
          status_d = ST_NOT_USED;
        end else if ((marks_rd_q & MARK_OPEN) != MARK_NONE) begin
          status_d = ST_STILL_OPEN;
        end else begin
          marks_we    = 1'b1;
          marks_wdata = marks_rd_q & ~MARK_USED;
          if (free_d < COUNT_MAX) begin
            ring_we = 1'b1;
            tail_d  = next_pos(tail_d);
            free_d  = free_d + 1'b1;
          end
          if (used_d != '0) used_d = used_d - 1'b1;
        end
      end
      OP_CLOSE: begin
        marks_we    = 1'b1;
        marks_wdata = marks_rd_q & ~MARK_OPEN;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && ring_we) begin
      ring_mem[ring_waddr] <= blk_q;
    end
    if (cmd_i.commit && marks_we) begin
      marks_mem[marks_waddr] <= marks_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LUNS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        free_q[i] <= '0;
        used_q[i] <= '0;
      end
      pend_valid_q <= 1'b0;
      pend_lun_q   <= '0;
      pend_blk_q   <= '0;
    end else if (cmd_i.commit) begin
      head_q[lun_eff] <= head_d;
      tail_q[lun_eff] <= tail_d;
      free_q[lun_eff] <= free_d;
      used_q[lun_eff] <= used_d;
      pend_valid_q    <= pend_valid_d;
      pend_lun_q      <= pend_lun_d;
      pend_blk_q      <= pend_blk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q   <= status_d;
      bout_q     <= bout_d;
      free_cnt_q <= free_d;
      used_cnt_q <= used_d;
    end
  end

  assign status_o     = status_q;
  assign block_out_o  = bout_q;
  assign free_count_o = free_cnt_q;
  assign used_count_o = used_cnt_q;

endmodule

>>> hw/rtl/flash_block_provisioner.sv
// flash_block_provisioner: top level of the per-lun erase block allocator
// depends on fbp_pkg, fbp_req_if, fbp_rsp_if, fbp_ctrl, fbp_datapath
//
//   channel  dir  handshake     payload
//   req_i    in   valid/ready   operation, lun, block, bad_planes, stored_used,
//                               stored_open, erase_ok
//   rsp_o    out  valid/ready   status, block_out, free_count, used_count
//
// an item is handled as a capture and a commit: the accept edge issues the registered reads of the
// free ring and the block marks, the commit edge applies the update and loads the
// result register; the one-port-per-side memories call for this split
// a finished result waits in the output register while the next item is taken;
// an item stalls in its update cycle only while the previous result is unread
// reset clears the ring pointers, counts and pending get; ring and mark memories
// need no clearing pass, blocks are loaded before use
module flash_block_provisioner import fbp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  fbp_req_if.sink   req_i,
  fbp_rsp_if.source rsp_o
);

  fbp_cmd_t cmd;

  // sequencer: ready, result valid and the capture/commit strobes
  fbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // storage and update logic, result payload comes straight from its register
  fbp_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .operation_i   (req_i.operation),
    .lun_i         (req_i.lun),
    .block_i       (req_i.block),
    .bad_planes_i  (req_i.bad_planes),
    .stored_used_i (req_i.stored_used),
    .stored_open_i (req_i.stored_open),
    .erase_ok_i    (req_i.erase_ok),
    .status_o      (rsp_o.status),
    .block_out_o   (rsp_o.block_out),
    .free_count_o  (rsp_o.free_count),
    .used_count_o  (rsp_o.used_count)
  );

endmodule

>>> verif/flash_block_provisioner_test.sv
`timescale 1ns / 1ps
// flash_block_provisioner_test: self-checking bench for the per-lun erase block allocator
// drives fbp_req_if items, checks fbp_rsp_if items against a scoreboard with its own predictor
// depends on fbp_pkg, fbp_req_if, fbp_rsp_if and flash_block_provisioner
module flash_block_provisioner_test;
  import fbp_pkg::*;

  // codes past close are reserved, the block answers them without a change
  localparam logic [OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RESERVED_LAST  = 3'd7;

  localparam int    SQUEEZE_CYCLES = 300;
  localparam int    TRAFFIC_ROUNDS = 280;
  localparam int    DRAIN_CYCLES   = 10;
  localparam real   RUN_LIMIT_NS   = 20_000_000.0;

  // one request item as it crosses req_i
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [LUN_W-1:0]  lun;
    logic [BLK_W-1:0]  block;
    logic [PLANES-1:0] bad_planes;
    logic              stored_used;
    logic              stored_open;
    logic              erase_ok;
  } alloc_item_t;

  // one reply item as it crosses rsp_o
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    block_out;
    logic [COUNT_W-1:0]  free_count;
    logic [COUNT_W-1:0]  used_count;
  } alloc_reply_t;

  // predicts the allocator item by item and holds the replies still owed
  class block_alloc_scoreboard;
    bit [BLK_W-1:0]  ring   [TOTAL_BLOCKS];
    bit [MARK_W-1:0] marks  [TOTAL_BLOCKS];
    int unsigned     head   [LUNS];
    int unsigned     tail   [LUNS];
    int unsigned     free_n [LUNS];
    int unsigned     used_n [LUNS];
    bit              grant_pending;
    int unsigned     grant_addr;
    alloc_reply_t    expected_replies [$];
    int unsigned     failures;

    function int unsigned advance(int unsigned p);
      return (p + 1 >= BLOCKS_PER_LUN) ? 0 : p + 1;
    endfunction

    // append to the tail of the lun's ring, dropped when the ring is full
    function void push_free(int unsigned lun, int unsigned blk);
      if (free_n[lun] >= BLOCKS_PER_LUN) return;
      ring[lun * BLOCKS_PER_LUN + tail[lun]] = BLK_W'(blk);
      tail[lun] = advance(tail[lun]);
      free_n[lun]++;
    endfunction

    function void bump_used(int unsigned lun);
      if (used_n[lun] < BLOCKS_PER_LUN) used_n[lun]++;
    endfunction

    function void drop_used(int unsigned lun);
      if (used_n[lun] > 0) used_n[lun]--;
    endfunction

    // apply one accepted item and queue the reply it must cause
    function alloc_reply_t note_request(alloc_item_t it);
      alloc_reply_t    r;
      int unsigned     lun;
      int unsigned     blk;
      int unsigned     addr;
      int unsigned     g;
      bit [MARK_W-1:0] m;
      lun         = it.lun % LUNS;
      blk         = it.block % BLOCKS_PER_LUN;
      addr        = lun * BLOCKS_PER_LUN + blk;
      r.status    = ST_OK;
      r.block_out = BLK_W'(blk);
      case (it.operation)
        OP_LOAD: begin
          if (it.bad_planes != '0) begin
            marks[addr] = MARK_BAD;
          end else if (it.stored_used) begin
            marks[addr] = MARK_USED | (it.stored_open ? MARK_OPEN : MARK_NONE);
            bump_used(lun);
          end else begin
            marks[addr] = MARK_NONE;
            push_free(lun, blk);
          end
        end
        OP_GET: begin
          if (free_n[lun] == 0) begin
            r.status    = ST_NO_FREE;
            r.block_out = '0;
          end else begin
            g         = ring[lun * BLOCKS_PER_LUN + head[lun]] % BLOCKS_PER_LUN;
            head[lun] = advance(head[lun]);
            free_n[lun]--;
            bump_used(lun);
            marks[lun * BLOCKS_PER_LUN + g] = MARK_USED;
            grant_pending = 1'b1;
            grant_addr    = lun * BLOCKS_PER_LUN + g;
            r.block_out   = BLK_W'(g);
          end
        end
        OP_ERASE: begin
          if (!grant_pending) begin
            r.status    = ST_NO_PENDING;
            r.block_out = '0;
          end else begin
            // counts come from the granted block's lun, not the item's
            lun         = grant_addr / BLOCKS_PER_LUN;
            r.block_out = BLK_W'(grant_addr % BLOCKS_PER_LUN);
            if (it.erase_ok) begin
              marks[grant_addr] = MARK_USED | MARK_OPEN;
            end else begin
              if ((marks[grant_addr] & MARK_USED) != '0) drop_used(lun);
              marks[grant_addr] = MARK_BAD;
              r.status          = ST_ERASE_FAIL;
            end
            grant_pending = 1'b0;
          end
        end
        OP_PUT: begin
          m = marks[addr];
          if ((m & MARK_USED) == '0) begin
            r.status = ST_NOT_USED;
          end else if ((m & MARK_OPEN) != '0) begin
            r.status = ST_STILL_OPEN;
          end else begin
            marks[addr] = m & ~MARK_USED;
            push_free(lun, blk);
            drop_used(lun);
          end
        end
        OP_CLOSE: marks[addr] = marks[addr] & ~MARK_OPEN;
        default: ;
      endcase
      r.free_count = COUNT_W'(free_n[lun]);
      r.used_count = COUNT_W'(used_n[lun]);
      expected_replies.push_back(r);
      return r;
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        failures++;
      end
    endfunction

    // compare an accepted reply with the oldest one owed
    function void check_reply(alloc_reply_t seen);
      alloc_reply_t want;
      if (expected_replies.size() == 0) begin
        $error("reply item with none owed: status %0d block_out %0d",
               seen.status, seen.block_out);
        failures++;
        return;
      end
      want = expected_replies.pop_front();
      compare_field("status", 16'(want.status), 16'(seen.status));
      compare_field("block_out", 16'(want.block_out), 16'(seen.block_out));
      compare_field("free_count", 16'(want.free_count), 16'(seen.free_count));
      compare_field("used_count", 16'(want.used_count), 16'(seen.used_count));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  fbp_req_if req_if ();
  fbp_rsp_if rsp_if ();

  flash_block_provisioner u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  block_alloc_scoreboard book = new();

  // blocks loaded so far per lun; put and close only ever name these,
  // so no never-written marks are read
  logic [BLK_W-1:0] loaded     [LUNS][$];
  bit               was_loaded [LUNS][BLOCKS_PER_LUN];

  // calm: no gaps on either side; squeeze_pending: ask the receiver for a long hold-off
  bit calm;
  bit squeeze_pending;

  // 20 ns clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // mostly short idle spans, now and then a long one
  function automatic int unsigned idle_span();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // lun 0 is the busy one, the rest share the remainder
  function automatic int unsigned pick_lun();
    int unsigned x;
    x = $urandom_range(0, 9);
    return (x < 4) ? 0 : 1 + (x - 4) % 3;
  endfunction

  function automatic logic [BLK_W-1:0] pick_loaded(int unsigned lun);
    return loaded[lun][$urandom_range(0, loaded[lun].size() - 1)];
  endfunction

  // item with random don't-care fields and the given operation, lun and block
  function automatic alloc_item_t shape(logic [OP_W-1:0] op, int unsigned lun,
                                        int unsigned blk);
    alloc_item_t it;
    it           = alloc_item_t'($urandom);
    it.operation = op;
    it.lun       = LUN_W'(lun);
    it.block     = BLK_W'(blk);
    return it;
  endfunction

  function automatic alloc_item_t load_of(int unsigned lun, int unsigned blk, int unsigned bad,
                                          bit su, bit so);
    alloc_item_t it;
    it             = shape(OP_LOAD, lun, blk);
    it.bad_planes  = PLANES'(bad);
    it.stored_used = su;
    it.stored_open = so;
    return it;
  endfunction

  // offer one item, hold it until accepted, then hand it to the predictor;
  // entered and left at a falling edge
  task automatic post_request(input alloc_item_t it, output alloc_reply_t r);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_span();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= it.operation;
    req_if.lun         <= it.lun;
    req_if.block       <= it.block;
    req_if.bad_planes  <= it.bad_planes;
    req_if.stored_used <= it.stored_used;
    req_if.stored_open <= it.stored_open;
    req_if.erase_ok    <= it.erase_ok;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    r = book.note_request(it);
    if (it.operation == OP_LOAD && !was_loaded[it.lun][it.block]) begin
      was_loaded[it.lun][it.block] = 1'b1;
      loaded[it.lun].push_back(it.block);
    end
    @(negedge clk_i);
  endtask

  // the usual life of a block: get, erase report, then mostly close and put back
  task automatic allocation_cycle(input int unsigned lun);
    alloc_item_t      it;
    alloc_reply_t     r;
    logic [BLK_W-1:0] blk;
    post_request(shape(OP_GET, lun, $urandom_range(0, BLOCKS_PER_LUN - 1)), r);
    if (r.status == ST_OK) begin
      blk         = r.block_out;
      it          = shape(OP_ERASE, $urandom_range(0, LUNS - 1), $urandom_range(0, 1023));
      it.erase_ok = ($urandom_range(0, 99) < 85);
      post_request(it, r);
      if (r.status == ST_OK) begin
        if ($urandom_range(0, 4) != 0) post_request(shape(OP_CLOSE, lun, blk), r);
        if ($urandom_range(0, 4) != 0) post_request(shape(OP_PUT, lun, blk), r);
      end
    end
  endtask

  // out-of-order traffic: stray loads, puts and closes, lone gets and erase reports, reserved codes
  task automatic stray_request();
    alloc_item_t  it;
    alloc_reply_t r;
    int unsigned  lun;
    int unsigned  k;
    lun = pick_lun();
    it  = shape(OP_LOAD, lun, $urandom_range(0, BLOCKS_PER_LUN - 1));
    k   = $urandom_range(0, 99);
    if (k < 15) begin
      // load with whatever fields came up
    end else if (k < 35) begin
      it.operation = OP_CLOSE;
      it.block     = pick_loaded(lun);
    end else if (k < 60) begin
      it.operation = OP_PUT;
      it.block     = pick_loaded(lun);
    end else if (k < 72) begin
      it.operation = OP_GET;
    end else if (k < 90) begin
      it.operation = OP_ERASE;
    end else begin
      it.operation = OP_W'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
    end
    post_request(it, r);
  endtask

  // reply side ready: random stalls, plus one long hold-off on request
  initial begin : reply_ready
    int unsigned stall;
    stall = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (squeeze_pending) begin
        squeeze_pending = 1'b0;
        stall           = SQUEEZE_CYCLES;
      end
      if (stall > 0) begin
        stall--;
        rsp_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall        = idle_span() - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // reply checker, sampled at the rising edge
  initial begin : reply_monitor
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        book.check_reply({rsp_if.status, rsp_if.block_out, rsp_if.free_count,
                          rsp_if.used_count});
    end
  end

  // hang guard
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("FAIL flash_block_provisioner");
    $finish;
  end

  initial begin : stimulus
    alloc_item_t  it;
    alloc_reply_t r;
    int unsigned  k;
    calm               = 1'b0;
    squeeze_pending    = 1'b0;
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.operation   <= OP_LOAD;
    req_if.lun         <= '0;
    req_if.block       <= '0;
    req_if.bad_planes  <= '0;
    req_if.stored_used <= 1'b0;
    req_if.stored_open <= 1'b0;
    req_if.erase_ok    <= 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, mostly on the top blocks of lun 3
    // empty ring, then an erase report with no get outstanding
    post_request(shape(OP_GET, 3, 0), r);
    it = shape(OP_ERASE, 0, 0);
    it.erase_ok = 1'b1;
    post_request(it, r);
    // one load of each kind; bad wins over stored used and open
    post_request(load_of(3, 1023, 0, 1'b0, 1'b0), r);
    post_request(load_of(3, 1022, 1, 1'b0, 1'b0), r);
    post_request(load_of(3, 1021, 2, 1'b1, 1'b1), r);
    post_request(load_of(3, 1020, 0, 1'b1, 1'b1), r);
    post_request(load_of(3, 1019, 0, 1'b1, 1'b0), r);
    post_request(load_of(3, 1018, 0, 1'b0, 1'b1), r);
    // put of a bad block, of an open block, then close and put back
    post_request(shape(OP_PUT, 3, 1022), r);
    post_request(shape(OP_PUT, 3, 1020), r);
    post_request(shape(OP_CLOSE, 3, 1020), r);
    post_request(shape(OP_PUT, 3, 1020), r);
    post_request(shape(OP_PUT, 3, 1019), r);
    // second get replaces the first; erase report ignores the item's lun
    post_request(shape(OP_GET, 3, 0), r);
    post_request(shape(OP_GET, 3, 0), r);
    it = shape(OP_ERASE, 0, 0);
    it.erase_ok = 1'b1;
    post_request(it, r);
    // failed erase of a block put back meanwhile: no longer used, count stays
    post_request(shape(OP_GET, 3, 0), r);
    post_request(shape(OP_PUT, 3, r.block_out), r);
    it = shape(OP_ERASE, 1, 0);
    it.erase_ok = 1'b0;
    post_request(it, r);
    // failed erase of a still used block
    post_request(shape(OP_GET, 3, 0), r);
    it = shape(OP_ERASE, 2, 1023);
    it.erase_ok = 1'b0;
    post_request(it, r);
    // reserved codes, a load over existing marks, a close of a bad block
    for (int c = OP_RESERVED_FIRST; c <= OP_RESERVED_LAST; c++)
      post_request(shape(OP_W'(c), 2, 1023), r);
    post_request(load_of(3, 1023, 3, 1'b1, 1'b1), r);
    post_request(shape(OP_CLOSE, 3, 1021), r);

    // lun 0 bring-up, all free, then two more free loads into the full ring
    for (int b = 0; b < BLOCKS_PER_LUN; b++)
      post_request(load_of(0, b, 0, 1'b0, 1'($urandom_range(0, 1))), r);
    repeat (2) post_request(load_of(0, $urandom_range(0, 1023), 0, 1'b0, 1'b0), r);

    // lun 1 bring-up, a short run of used blocks only
    calm = 1'b1;
    for (int b = 0; b < 128; b++)
      post_request(load_of(1, b, 0, 1'b1, 1'($urandom_range(0, 1))), r);
    calm = 1'b0;

    // luns 2 and 3: short bring-up with a mix of free, used and bad blocks
    for (int l = 2; l < LUNS; l++) begin
      for (int b = 0; b < 40; b++) begin
        k = $urandom_range(0, 9);
        if (k < 7)       post_request(load_of(l, b, 0, 1'b0, 1'($urandom_range(0, 1))), r);
        else if (k == 7) post_request(load_of(l, b, 0, 1'b1, 1'($urandom_range(0, 1))), r);
        else             post_request(load_of(l, b, $urandom_range(1, 3),
                                              1'($urandom_range(0, 1)),
                                              1'($urandom_range(0, 1))), r);
      end
    end

    // traffic: mostly whole allocation cycles, the rest stray items
    for (int n = 0; n < TRAFFIC_ROUNDS; n++) begin
      // long reply hold-off while items keep coming back to back
      if (n == 20) begin
        calm            = 1'b1;
        squeeze_pending = 1'b1;
      end
      if (n == 60) calm = 1'b0;
      if (n >= 100 && n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) allocation_cycle(pick_lun());
      else stray_request();
    end
    req_if.valid <= 1'b0;

    // wait for every owed reply, then keep watching for anything extra
    while (book.expected_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (book.failures == 0) begin
      $display("PASS flash_block_provisioner");
    end else begin
      $display("FAIL flash_block_provisioner");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/fbp_pkg.sv
hw/rtl/fbp_req_if.sv
hw/rtl/fbp_rsp_if.sv
hw/rtl/fbp_ctrl.sv
hw/rtl/fbp_datapath.sv
hw/rtl/flash_block_provisioner.sv
verif/flash_block_provisioner_test.sv
